FILE: sv/vfs_pkg.sv
// Shared types and constants for the valve and flow supervisor.
package vfs_pkg;

  localparam int OP_W          = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int DELAY_W       = 16;
  localparam int COUNT_W       = 27;
  localparam int LIMIT_W       = 26;
  localparam int MS_PER_S      = 1000;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_VALVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_PURE   = 3'd2;
  localparam logic [OP_W-1:0] OP_TAP    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLICK  = 3'd4;
  localparam logic [OP_W-1:0] OP_PRESS  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTOCLOSE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_DELAY       = 1'b1;

  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET     = 16'd60;
  localparam logic [DELAY_W-1:0]    ALERT_DELAY_RESET = 16'd2000;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET       = 26'(60 * MS_PER_S);
  localparam logic [DELAY_W-1:0]    DELAY_MAX         = '1;
  localparam logic [COUNT_W-1:0]    COUNT_MAX         = '1;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            level;
    logic            init_report;
  } vfs_in_t;

  typedef struct packed {
    logic valve_open;
    logic pure_alert;
    logic tap_alert;
    logic auto_closed;
  } vfs_out_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit_ms;
    logic [DELAY_W-1:0] alert_delay_ms;
  } vfs_cfg_t;

endpackage

FILE: sv/valve_flow_supervisor_top.sv
// Top level of the valve and flow supervisor: input register, update, result register.
// Takes one beat per clock cycle when the result side keeps up; an accepted beat is held in the
// input register, then the combinational state update writes its result into the result register,
// from which it is offered.
// A stalled result backs up into the input register, which then
// stalls the input. Configuration writes take effect at the next edge; the auto-close timeout
// is converted to milliseconds when it is written.
module valve_flow_supervisor_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vfs_pkg::vfs_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vfs_pkg::vfs_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [vfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  vfs_pkg::vfs_in_t  in_q;
  logic              in_q_valid;
  vfs_pkg::vfs_out_t out_q;
  logic              out_q_valid;
  vfs_pkg::vfs_cfg_t cfg;
  vfs_pkg::vfs_out_t result;
  logic              advance;
  logic              in_accept;

  assign advance   = in_q_valid && (!out_q_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  vfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vfs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid  <= 1'b0;
      out_q_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        out_q_valid <= 1'b1;
      end else if (!out_stall) begin
        out_q_valid <= 1'b0;
      end
    end
  end

  // payload registers: input loads on accept, result loads on advance, both hold while stalled
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q <= in_data;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid = out_q_valid;
  assign out_data  = out_q;

endmodule

FILE: sv/vfs_cfg.sv
// Configuration registers with the auto-close limit kept in milliseconds.
module vfs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  output vfs_pkg::vfs_cfg_t                   cfg
);

  logic [vfs_pkg::LIMIT_W-1:0] limit_ms;
  logic [vfs_pkg::DELAY_W-1:0] alert_delay_ms;
  logic [vfs_pkg::LIMIT_W-1:0] limit_next;

  // seconds to milliseconds, fits in 26 bits for any 16-bit timeout
  assign limit_next = vfs_pkg::LIMIT_W'(cfg_data) * vfs_pkg::LIMIT_W'(vfs_pkg::MS_PER_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_ms       <= vfs_pkg::LIMIT_RESET;
      alert_delay_ms <= vfs_pkg::ALERT_DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vfs_pkg::CFG_AUTOCLOSE_TIMEOUT: limit_ms       <= limit_next;
        vfs_pkg::CFG_ALERT_DELAY:       alert_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.limit_ms       = limit_ms;
  assign cfg.alert_delay_ms = alert_delay_ms;

endmodule

FILE: sv/vfs_core.sv
// Supervisor state and its one-step update for each item.
module vfs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  vfs_pkg::vfs_in_t  item,
  input  vfs_pkg::vfs_cfg_t cfg,
  output vfs_pkg::vfs_out_t result
);

  logic                        valve_is_open, valve_is_open_next;
  logic                        autoclose_armed, autoclose_armed_next;
  logic                        countdown_running, countdown_running_next;
  logic [vfs_pkg::COUNT_W-1:0] countdown_ms, countdown_ms_next;
  logic                        pure_delay_running, pure_delay_running_next;
  logic [vfs_pkg::DELAY_W-1:0] pure_delay_ms, pure_delay_ms_next;
  logic                        tap_delay_running, tap_delay_running_next;
  logic [vfs_pkg::DELAY_W-1:0] tap_delay_ms, tap_delay_ms_next;
  logic                        pure_alert_flag, pure_alert_flag_next;
  logic                        tap_alert_flag, tap_alert_flag_next;
  logic                        closed_now;

  logic [vfs_pkg::DELAY_W-1:0] pure_inc, tap_inc;
  logic [vfs_pkg::COUNT_W-1:0] count_inc;

  assign pure_inc  = (pure_delay_ms < vfs_pkg::DELAY_MAX) ? pure_delay_ms + 1'b1
                                                          : pure_delay_ms;
  assign tap_inc   = (tap_delay_ms < vfs_pkg::DELAY_MAX) ? tap_delay_ms + 1'b1
                                                         : tap_delay_ms;
  assign count_inc = (countdown_ms < vfs_pkg::COUNT_MAX) ? countdown_ms + 1'b1
                                                         : countdown_ms;

  always_comb begin
    valve_is_open_next      = valve_is_open;
    autoclose_armed_next    = autoclose_armed;
    countdown_running_next  = countdown_running;
    countdown_ms_next       = countdown_ms;
    pure_delay_running_next = pure_delay_running;
    pure_delay_ms_next      = pure_delay_ms;
    tap_delay_running_next  = tap_delay_running;
    tap_delay_ms_next       = tap_delay_ms;
    pure_alert_flag_next    = pure_alert_flag;
    tap_alert_flag_next     = tap_alert_flag;
    closed_now              = 1'b0;

    case (item.operation)
      vfs_pkg::OP_TICK: begin
        if (pure_delay_running) begin
          pure_delay_ms_next = pure_inc;
          if (pure_inc >= cfg.alert_delay_ms) begin
            pure_alert_flag_next    = 1'b1;
            pure_delay_running_next = 1'b0;
          end
        end
        if (tap_delay_running) begin
          tap_delay_ms_next = tap_inc;
          if (tap_inc >= cfg.alert_delay_ms) begin
            tap_alert_flag_next    = 1'b1;
            tap_delay_running_next = 1'b0;
          end
        end
        if (autoclose_armed && countdown_running) begin
          countdown_ms_next = count_inc;
          if (count_inc > {1'b0, cfg.limit_ms}) begin
            autoclose_armed_next   = 1'b0;
            countdown_running_next = 1'b0;
            countdown_ms_next      = '0;
            valve_is_open_next     = 1'b0;
            closed_now             = 1'b1;
          end
        end
      end
      vfs_pkg::OP_VALVE: begin
        if (!item.init_report) begin
          valve_is_open_next = item.level;
          if (item.level) begin
            if (!autoclose_armed) begin
              autoclose_armed_next   = 1'b1;
              countdown_running_next = 1'b1;
              countdown_ms_next      = '0;
            end
          end else begin
            autoclose_armed_next   = 1'b0;
            countdown_running_next = 1'b0;
            countdown_ms_next      = '0;
          end
        end
      end
      vfs_pkg::OP_PURE: begin
        if (!item.level) begin
          pure_delay_running_next = 1'b0;
          pure_delay_ms_next      = '0;
          // end of pure flow restarts an armed countdown from zero
          if (autoclose_armed) begin
            countdown_running_next = 1'b1;
            countdown_ms_next      = '0;
          end
        end else begin
          countdown_running_next = 1'b0;
          countdown_ms_next      = '0;
          if (!valve_is_open && !pure_delay_running) begin
            pure_delay_running_next = 1'b1;
            pure_delay_ms_next      = '0;
          end
        end
      end
      vfs_pkg::OP_TAP: begin
        if (!item.level) begin
          tap_delay_running_next = 1'b0;
          tap_delay_ms_next      = '0;
        end else if (valve_is_open && !tap_delay_running) begin
          tap_delay_running_next = 1'b1;
          tap_delay_ms_next      = '0;
        end
      end
      vfs_pkg::OP_CLICK: begin
        valve_is_open_next = 1'b1;
      end
      vfs_pkg::OP_PRESS: begin
        valve_is_open_next   = 1'b0;
        pure_alert_flag_next = 1'b0;
        tap_alert_flag_next  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valve_is_open      <= 1'b0;
      autoclose_armed    <= 1'b0;
      countdown_running  <= 1'b0;
      countdown_ms       <= '0;
      pure_delay_running <= 1'b0;
      pure_delay_ms      <= '0;
      tap_delay_running  <= 1'b0;
      tap_delay_ms       <= '0;
      pure_alert_flag    <= 1'b0;
      tap_alert_flag     <= 1'b0;
    end else if (step) begin
      valve_is_open      <= valve_is_open_next;
      autoclose_armed    <= autoclose_armed_next;
      countdown_running  <= countdown_running_next;
      countdown_ms       <= countdown_ms_next;
      pure_delay_running <= pure_delay_running_next;
      pure_delay_ms      <= pure_delay_ms_next;
      tap_delay_running  <= tap_delay_running_next;
      tap_delay_ms       <= tap_delay_ms_next;
      pure_alert_flag    <= pure_alert_flag_next;
      tap_alert_flag     <= tap_alert_flag_next;
    end
  end

  assign result.valve_open  = valve_is_open_next;
  assign result.pure_alert  = pure_alert_flag_next;
  assign result.tap_alert   = tap_alert_flag_next;
  assign result.auto_closed = closed_now;

  a_autoclose_shuts: assert property (@(posedge clk) disable iff (rst)
    step && closed_now |=> !valve_is_open && !autoclose_armed)
    else $error("auto close left the valve open or armed");

  a_disarmed_idle: assert property (@(posedge clk) disable iff (rst)
    !autoclose_armed |-> !countdown_running && countdown_ms == '0)
    else $error("countdown active while disarmed");

  a_press_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.operation == vfs_pkg::OP_PRESS |=> !pure_alert_flag && !tap_alert_flag)
    else $error("long press did not clear alerts");

endmodule

FILE: tb/sv/valve_flow_supervisor_top_tb.sv
// Self-checking testbench for the valve and flow supervisor: directed plan, then random phases.
module valve_flow_supervisor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [vfs_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [vfs_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam int LONG_HOLD = 60;

  typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    vfs_pkg::vfs_in_t               beat;
    bit                             typed;
    vfs_pkg::vfs_out_t              want;
    logic [vfs_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [vfs_pkg::CFG_DATA_W-1:0] reg_val;
  } plan_row_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  vfs_pkg::vfs_in_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  vfs_pkg::vfs_out_t              out_data;
  logic                           cfg_we;
  logic [vfs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vfs_pkg::CFG_DATA_W-1:0] cfg_data;

  valve_flow_supervisor_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // supervisor model state
  logic [vfs_pkg::CFG_DATA_W-1:0] timeout_s;
  logic [vfs_pkg::DELAY_W-1:0]    alert_delay;
  bit                             valve;
  bit                             armed;
  bit                             cd_running;
  logic [vfs_pkg::COUNT_W-1:0]    cd_ms;
  bit                             pure_run;
  logic [vfs_pkg::DELAY_W-1:0]    pure_ms;
  bit                             tap_run;
  logic [vfs_pkg::DELAY_W-1:0]    tap_ms;
  bit                             pure_flag;
  bit                             tap_flag;

  vfs_pkg::vfs_out_t expected_status[$];
  vfs_pkg::vfs_in_t  beat_backlog[$];
  plan_row_t         plan[$];
  int                fail_count;
  bit                src_idle_on;
  bit                sink_idle_on;
  bit                long_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic age_alert(inout bit run, inout logic [vfs_pkg::DELAY_W-1:0] cnt,
                           inout bit flag);
    if (run) begin
      if (cnt != vfs_pkg::DELAY_MAX) cnt = cnt + 1'b1;
      if (cnt >= alert_delay) begin
        flag = 1'b1;
        run  = 1'b0;
      end
    end
  endtask

  task automatic supervise_beat(input vfs_pkg::vfs_in_t b, output vfs_pkg::vfs_out_t st);
    int unsigned limit_ms;
    bit          closed_now;
    closed_now = 1'b0;
    limit_ms   = 32'(timeout_s) * vfs_pkg::MS_PER_S;
    case (b.operation)
      vfs_pkg::OP_TICK: begin
        age_alert(pure_run, pure_ms, pure_flag);
        age_alert(tap_run, tap_ms, tap_flag);
        if (armed && cd_running) begin
          if (cd_ms != vfs_pkg::COUNT_MAX) cd_ms = cd_ms + 1'b1;
          if (32'(cd_ms) > limit_ms) begin
            armed      = 1'b0;
            cd_running = 1'b0;
            cd_ms      = '0;
            valve      = 1'b0;
            closed_now = 1'b1;
          end
        end
      end
      vfs_pkg::OP_VALVE: begin
        if (!b.init_report) begin
          valve = b.level;
          if (b.level) begin
            if (!armed) begin
              armed      = 1'b1;
              cd_running = 1'b1;
              cd_ms      = '0;
            end
          end else begin
            armed      = 1'b0;
            cd_running = 1'b0;
            cd_ms      = '0;
          end
        end
      end
      vfs_pkg::OP_PURE: begin
        if (!b.level) begin
          pure_run = 1'b0;
          pure_ms  = '0;
          // end of pure flow restarts an armed countdown
          if (armed) begin
            cd_running = 1'b1;
            cd_ms      = '0;
          end
        end else begin
          cd_running = 1'b0;
          cd_ms      = '0;
          if (!valve && !pure_run) begin
            pure_run = 1'b1;
            pure_ms  = '0;
          end
        end
      end
      vfs_pkg::OP_TAP: begin
        if (!b.level) begin
          tap_run = 1'b0;
          tap_ms  = '0;
        end else if (valve && !tap_run) begin
          tap_run = 1'b1;
          tap_ms  = '0;
        end
      end
      vfs_pkg::OP_CLICK: valve = 1'b1;
      vfs_pkg::OP_PRESS: begin
        valve     = 1'b0;
        pure_flag = 1'b0;
        tap_flag  = 1'b0;
      end
      default: ;
    endcase
    st.valve_open  = valve;
    st.pure_alert  = pure_flag;
    st.tap_alert   = tap_flag;
    st.auto_closed = closed_now;
  endtask

  function automatic plan_row_t beat_row(input logic [vfs_pkg::OP_W-1:0] op, input bit lvl,
                                         input bit ini, input bit typed, input logic [3:0] want);
    plan_row_t r;
    r.kind                 = ROW_BEAT;
    r.beat.operation       = op;
    r.beat.level           = lvl;
    r.beat.init_report     = ini;
    r.typed                = typed;
    r.want                 = vfs_pkg::vfs_out_t'(want);
    r.reg_idx              = '0;
    r.reg_val              = '0;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [vfs_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [vfs_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r         = beat_row(vfs_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 4'b0000);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic stage(input logic [vfs_pkg::OP_W-1:0] op, input bit lvl, input bit ini);
    vfs_pkg::vfs_in_t b;
    b.operation   = op;
    b.level       = lvl;
    b.init_report = ini;
    beat_backlog.push_back(b);
  endtask

  task automatic stage_ticks(input int n);
    repeat (n) stage(vfs_pkg::OP_TICK, 1'b0, 1'b0);
  endtask

  // Mostly well-formed episodes with random content, plus some noise.
  task automatic plan_scenario(input int max_ticks);
    int                           pick;
    logic [vfs_pkg::OP_W-1:0]     flow;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      flow = $urandom_range(0, 1) ? vfs_pkg::OP_PURE : vfs_pkg::OP_TAP;
      stage(flow, 1'b1, 1'b0);
      stage_ticks($urandom_range(0, max_ticks));
      if ($urandom_range(0, 3) != 0) stage(flow, 1'b0, 1'b0);
    end else if (pick < 50) begin
      if ($urandom_range(0, 2) != 0) stage(vfs_pkg::OP_VALVE, 1'b1, 1'b0);
      else stage(vfs_pkg::OP_CLICK, 1'b0, 1'b0);
      stage_ticks($urandom_range(0, max_ticks));
      if ($urandom_range(0, 1)) begin
        stage(vfs_pkg::OP_PURE, 1'b1, 1'b0);
        stage_ticks($urandom_range(0, 4));
        stage(vfs_pkg::OP_PURE, 1'b0, 1'b0);
        stage_ticks($urandom_range(0, max_ticks));
      end
      if ($urandom_range(0, 2) == 0) stage(vfs_pkg::OP_VALVE, 1'b0, 1'b0);
    end else if (pick < 70) begin
      stage_ticks($urandom_range(1, max_ticks));
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0:       stage(vfs_pkg::OP_CLICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1:       stage(vfs_pkg::OP_PRESS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: stage(vfs_pkg::OP_VALVE, 1'($urandom_range(0, 1)), 1'b0);
      endcase
    end else begin
      stage(vfs_pkg::OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
    end
  endtask

  // Offer one beat, hold it until accepted, then record what it should produce.
  task automatic send_beat(input vfs_pkg::vfs_in_t b, input bit typed,
                           input vfs_pkg::vfs_out_t want);
    int                gap;
    vfs_pkg::vfs_out_t pred;
    gap = src_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    supervise_beat(b, pred);
    expected_status.push_back(typed ? want : pred);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vfs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == vfs_pkg::CFG_AUTOCLOSE_TIMEOUT) timeout_s = val;
    else alert_delay = val;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [vfs_pkg::CFG_DATA_W-1:0] tmo,
                           input logic [vfs_pkg::DELAY_W-1:0] dly,
                           input int n_beats, input int hold_at, input int pause_at);
    int               counted;
    int               max_ticks;
    vfs_pkg::vfs_in_t b;
    drain();
    write_reg(vfs_pkg::CFG_AUTOCLOSE_TIMEOUT, tmo);
    write_reg(vfs_pkg::CFG_ALERT_DELAY, dly);
    max_ticks = (alert_delay < 40) ? int'(alert_delay) + 3 : 12;
    counted   = 0;
    while (counted < n_beats) begin
      if (counted % 40 == 0) begin
        src_idle_on  = $urandom_range(0, 2) != 0;
        sink_idle_on = $urandom_range(0, 2) != 0;
      end
      if (counted == hold_at) begin
        // keep offering beats while the result side backs up
        src_idle_on   = 1'b0;
        long_hold_req = 1'b1;
      end
      if (counted == pause_at) drain();
      if (beat_backlog.size() == 0) plan_scenario(max_ticks);
      b = beat_backlog.pop_front();
      send_beat(b, 1'b0, '0);
      if (!((b.operation == vfs_pkg::OP_VALVE && b.init_report) ||
            b.operation > vfs_pkg::OP_PRESS)) counted++;
    end
    beat_backlog.delete();
  endtask

  // result side: random stalls, compare each beat with the oldest expectation
  initial begin : status_sink
    int                wait_cycles;
    vfs_pkg::vfs_out_t want;
    vfs_pkg::vfs_out_t got;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      wait_cycles = sink_idle_on ? $urandom_range(0, 6) : 0;
      if (long_hold_req) begin
        wait_cycles   = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      if (expected_status.size() == 0) begin
        note_failure($sformatf("unexpected result beat %b", got));
      end else begin
        want = expected_status.pop_front();
        if (got.valve_open !== want.valve_open || got.pure_alert !== want.pure_alert ||
            got.tap_alert !== want.tap_alert || got.auto_closed !== want.auto_closed)
          note_failure($sformatf(
            "status mismatch: expected open=%b pure=%b tap=%b auto=%b, got %b %b %b %b",
            want.valve_open, want.pure_alert, want.tap_alert, want.auto_closed,
            got.valve_open, got.pure_alert, got.tap_alert, got.auto_closed));
      end
    end
  end

  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    fail_count    = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    long_hold_req = 1'b0;
    timeout_s   = vfs_pkg::TIMEOUT_RESET;
    alert_delay = vfs_pkg::ALERT_DELAY_RESET;
    valve = 1'b0; armed = 1'b0; cd_running = 1'b0; cd_ms = '0;
    pure_run = 1'b0; pure_ms = '0; tap_run = 1'b0; tap_ms = '0;
    pure_flag = 1'b0; tap_flag = 1'b0;

    // columns of the typed status: valve_open, pure_alert, tap_alert, auto_closed
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b1, 4'b0000));
    plan.push_back(beat_row(OP_SPARE6,         1'b0, 1'b0, 1'b1, 4'b0000));
    plan.push_back(beat_row(OP_SPARE7,         1'b1, 1'b1, 1'b1, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_VALVE, 1'b1, 1'b1, 1'b1, 4'b0000));
    plan.push_back(reg_row(vfs_pkg::CFG_AUTOCLOSE_TIMEOUT, 16'd0));
    plan.push_back(reg_row(vfs_pkg::CFG_ALERT_DELAY, 16'd1));
    // pure flow on a closed valve raises its alert after one tick
    plan.push_back(beat_row(vfs_pkg::OP_PURE,  1'b1, 1'b0, 1'b1, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b1, 4'b0100));
    // zero timeout closes on the first tick
    plan.push_back(beat_row(vfs_pkg::OP_VALVE, 1'b1, 1'b0, 1'b1, 4'b1100));
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b1, 4'b0101));
    plan.push_back(beat_row(vfs_pkg::OP_CLICK, 1'b0, 1'b0, 1'b1, 4'b1100));
    plan.push_back(beat_row(vfs_pkg::OP_TAP,   1'b1, 1'b0, 1'b1, 4'b1100));
    plan.push_back(beat_row(vfs_pkg::OP_TAP,   1'b1, 1'b0, 1'b1, 4'b1100));
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b1, 4'b1110));
    plan.push_back(beat_row(vfs_pkg::OP_PRESS, 1'b1, 1'b0, 1'b1, 4'b0000));
    // pure flow pauses the countdown, its end restarts it
    plan.push_back(beat_row(vfs_pkg::OP_VALVE, 1'b1, 1'b0, 1'b1, 4'b1000));
    plan.push_back(beat_row(vfs_pkg::OP_PURE,  1'b1, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_PURE,  1'b0, 1'b0, 1'b0, 4'b0000));
    // press leaves the countdown armed, so it still expires
    plan.push_back(beat_row(vfs_pkg::OP_PRESS, 1'b0, 1'b0, 1'b1, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b1, 4'b0001));
    plan.push_back(reg_row(vfs_pkg::CFG_AUTOCLOSE_TIMEOUT, 16'hFFFF));
    plan.push_back(reg_row(vfs_pkg::CFG_ALERT_DELAY, 16'hFFFF));
    plan.push_back(beat_row(vfs_pkg::OP_VALVE, 1'b1, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_TAP,   1'b1, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_VALVE, 1'b0, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_TAP,   1'b0, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_PURE,  1'b1, 1'b0, 1'b0, 4'b0000));
    plan.push_back(beat_row(vfs_pkg::OP_PURE,  1'b0, 1'b0, 1'b0, 4'b0000));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    run_phase(16'd0,    16'd1,    200, -1,  -1);
    run_phase(16'hFFFF, 16'hFFFF, 120, -1,  60);
    run_phase(16'd1,    16'd3,    200, 50,  -1);
    run_phase(16'($urandom_range(0, 3)), 16'($urandom_range(1, 40)), 200, -1, -1);
    run_phase(vfs_pkg::TIMEOUT_RESET, vfs_pkg::ALERT_DELAY_RESET, 150, -1, -1);
    run_phase(16'd0,    16'd7,    200, 120, -1);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
